### hw/rtl/der_ecdsa_signature_to_raw_assert.svh
// Assertion macros for the top level of the signature converter RTL.
`ifndef DER_ECDSA_SIGNATURE_TO_RAW_ASSERT_SVH
`define DER_ECDSA_SIGNATURE_TO_RAW_ASSERT_SVH

// Check a same-cycle implication on the rising edge of clk, outside reset.
`define DSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle, outside reset.
`define DSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/dsr_pkg.sv
// Shared types and constants of the DER signature to raw converter.
`default_nettype none
package dsr_pkg;

  localparam int SIG_BYTES  = 64;
  localparam int HALF_BYTES = SIG_BYTES / 2;
  localparam int RESULT_CAP = 32;
  localparam int PAD_W      = $clog2(RESULT_CAP + 1);
  localparam int REM_W      = $clog2(HALF_BYTES + 1);
  localparam int CMD_DEPTH  = 4;
  localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_SEQ = 3'd1,
    ST_SHORT   = 3'd2,
    ST_BAD_R   = 3'd3,
    ST_BAD_S   = 3'd4,
    ST_TRUNC   = 3'd5
  } status_t;

  // One parsed input byte: a zero-pad burst, an optional data byte, an optional error.
  typedef struct packed {
    logic [PAD_W-1:0] pad_cnt;
    logic             pad_last;
    logic             has_byte;
    logic [7:0]       data;
    logic             data_last;
    logic             has_err;
    status_t          err;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage
`default_nettype wire

### hw/rtl/dsr_cmd_fifo.sv
// Short command queue between the parser and the result expander.
`default_nettype none
module dsr_cmd_fifo
  import dsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  cmd_t       wr_cmd,
  input  logic       rd_en,
  output cmd_t       rd_cmd,
  output fifo_stat_t stat
);

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_CNT_W-1:0] cnt_r;

  assign stat.full  = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_cmd     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + CMD_PTR_W'(1);
      if (rd_en) rd_ptr_r <= rd_ptr_r + CMD_PTR_W'(1);
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + CMD_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CMD_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/dsr_parse.sv
// Front end: walks the DER structure one byte per transaction and issues commands.
`default_nettype none
module dsr_parse
  import dsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_frame_start,
  input  logic       in_frame_end,
  output logic       cmd_push,
  output cmd_t       cmd
);

  typedef enum logic [8:0] {
    PH_SEQ_TAG = 9'b000000001,
    PH_SEQ_LEN = 9'b000000010,
    PH_R_TAG   = 9'b000000100,
    PH_R_LEN   = 9'b000001000,
    PH_R_BODY  = 9'b000010000,
    PH_S_TAG   = 9'b000100000,
    PH_S_LEN   = 9'b001000000,
    PH_S_BODY  = 9'b010000000,
    PH_DONE    = 9'b100000000
  } phase_t;

  localparam logic [7:0] HALF_B = 8'(HALF_BYTES);
  localparam logic [7:0] SIG_B  = 8'(SIG_BYTES);
  localparam logic [7:0] CAP_B  = 8'(RESULT_CAP);

  phase_t           phase_r, phase_nxt, phase_e;
  logic [REM_W-1:0] rem_r, rem_nxt, rem_e, rem_dec;
  logic [7:0]       skip_r, skip_nxt, skip_e;
  logic             failed_r, failed_nxt, failed_e;

  logic             short_len;
  logic [7:0]       pad_full, skip_len;
  logic [PAD_W-1:0] pad_cnt;
  logic [REM_W-1:0] rem_len;
  logic             is_s;
  status_t          err;

  // Length byte decode, shared by R and S.
  assign short_len = (in_byte < HALF_B);
  assign pad_full  = HALF_B - in_byte;
  assign pad_cnt   = !short_len ? '0 :
                     (pad_full > CAP_B) ? PAD_W'(RESULT_CAP) : pad_full[PAD_W-1:0];
  assign skip_len  = short_len ? 8'd0 : (in_byte - HALF_B);
  assign rem_len   = short_len ? in_byte[REM_W-1:0] : REM_W'(HALF_BYTES);

  always_comb begin
    phase_e  = in_frame_start ? PH_SEQ_TAG : phase_r;
    rem_e    = in_frame_start ? '0 : rem_r;
    skip_e   = in_frame_start ? 8'd0 : skip_r;
    failed_e = in_frame_start ? 1'b0 : failed_r;
    rem_dec  = rem_e - REM_W'(1);

    phase_nxt  = phase_e;
    rem_nxt    = rem_e;
    skip_nxt   = skip_e;
    failed_nxt = failed_e;
    is_s       = 1'b0;
    err        = ST_OK;
    cmd        = '0;
    cmd.err    = ST_OK;

    if (!failed_e && phase_e != PH_DONE) begin
      case (phase_e)
        PH_SEQ_TAG: begin
          if (in_byte != TAG_SEQUENCE) err = ST_BAD_SEQ;
          else phase_nxt = PH_SEQ_LEN;
        end
        PH_SEQ_LEN: begin
          if (in_byte < SIG_B) err = ST_SHORT;
          else phase_nxt = PH_R_TAG;
        end
        PH_R_TAG: begin
          if (in_byte != TAG_INTEGER) err = ST_BAD_R;
          else phase_nxt = PH_R_LEN;
        end
        PH_S_TAG: begin
          if (in_byte != TAG_INTEGER) err = ST_BAD_S;
          else phase_nxt = PH_S_LEN;
        end
        PH_R_LEN, PH_S_LEN: begin
          is_s         = (phase_e == PH_S_LEN);
          skip_nxt     = skip_len;
          rem_nxt      = rem_len;
          cmd.pad_cnt  = pad_cnt;
          // Last flag sits on the final pad only when S is empty and the burst fits.
          cmd.pad_last = is_s && (in_byte == 8'd0) && (HALF_BYTES <= RESULT_CAP);
          if (rem_len == '0) phase_nxt = is_s ? PH_DONE : PH_S_TAG;
          else               phase_nxt = is_s ? PH_S_BODY : PH_R_BODY;
        end
        PH_R_BODY, PH_S_BODY: begin
          is_s = (phase_e == PH_S_BODY);
          if (skip_e != 8'd0) begin
            skip_nxt = skip_e - 8'd1;
          end else begin
            rem_nxt       = rem_dec;
            cmd.has_byte  = 1'b1;
            cmd.data      = in_byte;
            cmd.data_last = is_s && (rem_dec == '0);
            if (rem_dec == '0) phase_nxt = is_s ? PH_DONE : PH_S_TAG;
          end
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase

      if (err == ST_OK && in_frame_end && phase_nxt != PH_DONE) err = ST_TRUNC;
      if (err != ST_OK) begin
        failed_nxt  = 1'b1;
        // The error result falls off the end when a full pad burst came first.
        cmd.has_err = (cmd.pad_cnt != PAD_W'(RESULT_CAP));
        cmd.err     = err;
      end
    end

    cmd_push = accept && (cmd.pad_cnt != '0 || cmd.has_byte || cmd.has_err);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEQ_TAG;
      rem_r    <= '0;
      skip_r   <= '0;
      failed_r <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      rem_r    <= rem_nxt;
      skip_r   <= skip_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/dsr_expand.sv
// Back end: expands each command into result transactions through an output register.
`default_nettype none
module dsr_expand
  import dsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head,
  input  fifo_stat_t fifo_stat,
  output logic       cmd_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic [2:0] out_status,
  output logic       out_last_of_signature
);

  logic [PAD_W-1:0] pad_idx_r;
  logic             byte_done_r;
  logic             out_valid_r;
  logic [7:0]       byte_r;
  status_t          status_r;
  logic             last_r;

  logic             in_pad, in_data, pad_final, fin, go;
  logic [7:0]       byte_nxt;
  status_t          status_nxt;
  logic             last_nxt;

  assign in_pad    = (pad_idx_r < head.pad_cnt);
  assign in_data   = !in_pad && head.has_byte && !byte_done_r;
  assign pad_final = (pad_idx_r == head.pad_cnt - PAD_W'(1));
  assign go        = !fifo_stat.empty && (!out_valid_r || pop);
  assign cmd_pop   = go && fin;

  always_comb begin
    if (in_pad) begin
      byte_nxt   = 8'd0;
      status_nxt = ST_OK;
      last_nxt   = head.pad_last && pad_final;
      fin        = pad_final && !head.has_byte && !head.has_err;
    end else if (in_data) begin
      byte_nxt   = head.data;
      status_nxt = ST_OK;
      last_nxt   = head.data_last;
      fin        = !head.has_err;
    end else begin
      byte_nxt   = 8'd0;
      status_nxt = head.err;
      last_nxt   = 1'b1;
      fin        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_idx_r   <= '0;
      byte_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        out_valid_r <= 1'b1;
        if (fin) begin
          pad_idx_r   <= '0;
          byte_done_r <= 1'b0;
        end else if (in_pad) begin
          pad_idx_r <= pad_idx_r + PAD_W'(1);
        end else begin
          byte_done_r <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      byte_r   <= byte_nxt;
      status_r <= status_nxt;
      last_r   <= last_nxt;
    end
  end

  assign empty                 = !out_valid_r;
  assign out_byte              = byte_r;
  assign out_status            = status_r;
  assign out_last_of_signature = last_r;

endmodule
`default_nettype wire

### hw/rtl/der_ecdsa_signature_to_raw.sv
// A pushed byte reaches the result side through the command queue and the output register.
// Throughput: one input byte and one result per cycle unless full or a low pop stalls;
//   a padding length byte expands to up to RESULT_CAP results, taken one per cycle by the expander.
// Four queued commands let the parser run ahead; behind a pad burst full stays high
//   until the head command drains, and longer while pop stalls.
// Reset (rst_n low, synchronous): parser expects a sequence tag, command queue and output empty.
`default_nettype none
`include "der_ecdsa_signature_to_raw_assert.svh"
module der_ecdsa_signature_to_raw
  import dsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input transaction: one DER byte
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_frame_start,
  input  logic       in_frame_end,
  // result transaction: one raw byte or one error
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [2:0] out_status,
  output logic       out_last_of_signature
);

  logic       accept;
  logic       cmd_push;
  logic       cmd_pop;
  cmd_t       cmd_in;
  cmd_t       cmd_head;
  fifo_stat_t fifo_stat;

  // Hold the input side whenever the command queue has no free slot.
  assign full   = fifo_stat.full;
  assign accept = push && !fifo_stat.full;

  // Front: classify each byte against the DER layout, update the phase.
  dsr_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_byte        (in_byte),
    .in_frame_start (in_frame_start),
    .in_frame_end   (in_frame_end),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in)
  );

  // Decouple parsing from result delivery so each side can stall alone.
  dsr_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_cmd (cmd_in),
    .rd_en  (cmd_pop),
    .rd_cmd (cmd_head),
    .stat   (fifo_stat)
  );

  // Back: drain pad bursts, data bytes and errors into the output register.
  dsr_expand u_expand (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head                  (cmd_head),
    .fifo_stat             (fifo_stat),
    .cmd_pop               (cmd_pop),
    .pop                   (pop),
    .empty                 (empty),
    .out_byte              (out_byte),
    .out_status            (out_status),
    .out_last_of_signature (out_last_of_signature)
  );

  // An error result always closes the signature.
  `DSR_ASSERT_NOW(a_err_last, !empty && out_status != ST_OK, out_last_of_signature,
    "error result without last flag")
  // An error result carries a zero byte.
  `DSR_ASSERT_NOW(a_err_zero, !empty && out_status != ST_OK, out_byte == 8'd0,
    "error result with nonzero byte")
  // The command queue is never full and empty at once.
  `DSR_ASSERT_NOW(a_fifo_sane, 1'b1, !(fifo_stat.full && fifo_stat.empty),
    "command queue full and empty together")
  // Taking a command from a full queue frees a slot by the next cycle.
  `DSR_ASSERT_NEXT(a_pop_nonempty, cmd_pop && !cmd_push && fifo_stat.full, !fifo_stat.full,
    "command queue stayed full after a pop")

endmodule
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the DER ECDSA signature to raw R||S converter.
`default_nettype none
module testbench;
  import dsr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_MAX   = 20;

  // Parser position, tracked by the predictor alongside the block.
  typedef enum logic [3:0] {
    P_SEQ_TAG, P_SEQ_LEN, P_R_TAG, P_R_LEN, P_R_BODY,
    P_S_TAG, P_S_LEN, P_S_BODY, P_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    status_t    status;
    logic       last;
  } raw_result_t;

  typedef struct packed {
    logic [7:0] b;
    logic       s;
    logic       e;
  } der_item_t;

  // One directed transaction; typed rows carry the single error result they must give.
  typedef struct packed {
    logic [7:0] b;
    logic       s;
    logic       e;
    logic       typed;
    status_t    st;
  } der_row_t;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       in_frame_start;
  logic       in_frame_end;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic [2:0] out_status;
  logic       out_last_of_signature;

  der_ecdsa_signature_to_raw dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .push                  (push),
    .full                  (full),
    .in_byte               (in_byte),
    .in_frame_start        (in_frame_start),
    .in_frame_end          (in_frame_end),
    .empty                 (empty),
    .pop                   (pop),
    .out_byte              (out_byte),
    .out_status            (out_status),
    .out_last_of_signature (out_last_of_signature)
  );

  // Predictor state: a private copy of the parser.
  parse_phase_t phase_q;
  logic [7:0]   remain_q;
  logic [7:0]   skip_q;
  logic         failed_q;

  raw_result_t  step_out[$];   // results of the byte being predicted
  raw_result_t  raw_fifo[$];   // raw bytes and errors still owed by the block
  der_item_t    frame_q[$];    // random signature under construction

  // Directed-row expectation, driven along with the input transaction.
  logic    row_typed;
  status_t row_status;

  int send_idle_pct;
  int stall_pct;
  bit hold_req;

  int cycle_cnt;
  int byte_cnt;
  int live_cnt;
  int result_cnt;
  int frame_cnt;
  int mismatch_cnt;

  // Directed part: reset state, length boundary, every error code, padding and
  // dropping of surplus bytes, zero-length integers, early end, and bytes that
  // must be ignored after completion.
  der_row_t dir_rows [0:24] = '{
    // no frame start after reset: the parser already wants a sequence tag
    '{8'h31, 1'b0, 1'b0, 1'b1, ST_BAD_SEQ},
    // sequence length one below the minimum
    '{TAG_SEQUENCE, 1'b1, 1'b0, 1'b0, ST_OK},
    '{8'(SIG_BYTES - 1), 1'b0, 1'b0, 1'b1, ST_SHORT},
    // length exactly at the minimum, then a wrong R tag
    '{TAG_SEQUENCE, 1'b1, 1'b0, 1'b0, ST_OK},
    '{8'(SIG_BYTES), 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h03, 1'b0, 1'b0, 1'b1, ST_BAD_R},
    // largest sequence length, zero-length R (all padding), then a wrong S tag
    '{TAG_SEQUENCE, 1'b1, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
    '{TAG_INTEGER, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h05, 1'b0, 1'b0, 1'b1, ST_BAD_S},
    // R one byte too long: drop the surplus byte, then end early
    '{TAG_SEQUENCE, 1'b1, 1'b0, 1'b0, ST_OK},
    '{8'(SIG_BYTES + 6), 1'b0, 1'b0, 1'b0, ST_OK},
    '{TAG_INTEGER, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'(HALF_BYTES + 1), 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b1, 1'b1, ST_TRUNC},
    // both integers empty: the last S pad closes the signature
    '{TAG_SEQUENCE, 1'b1, 1'b0, 1'b0, ST_OK},
    '{8'(SIG_BYTES), 1'b0, 1'b0, 1'b0, ST_OK},
    '{TAG_INTEGER, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
    '{TAG_INTEGER, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b1, 1'b0, ST_OK},
    // trailing byte after completion: ignore it
    '{8'hAA, 1'b0, 1'b1, 1'b0, ST_OK},
    // bad tag on a frame-end byte gives exactly one error
    '{8'h00, 1'b1, 1'b1, 1'b1, ST_BAD_SEQ},
    // good tag but the frame ends right away
    '{TAG_SEQUENCE, 1'b1, 1'b1, 1'b1, ST_TRUNC}
  };

  int idle_by_phase  [0:3] = '{0, 54, 0, 34};
  int stall_by_phase [0:3] = '{0, 0, 54, 34};

  // ---------------------------------------------------------------- predictor

  task automatic clear_parser();
    phase_q  = P_SEQ_TAG;
    remain_q = '0;
    skip_q   = '0;
    failed_q = 1'b0;
  endtask

  // Drop anything past the per-byte result cap, as the block does.
  task automatic emit_raw(input logic [7:0] b, input status_t st, input logic last);
    raw_result_t r;
    r.data   = b;
    r.status = st;
    r.last   = last;
    if (step_out.size() < RESULT_CAP) step_out.push_back(r);
  endtask

  task automatic take_int_len(input logic [7:0] len, input bit is_s);
    int pad;
    if (len < HALF_BYTES) begin
      pad      = HALF_BYTES - len;
      skip_q   = '0;
      remain_q = len;
    end else begin
      pad      = 0;
      skip_q   = 8'(len - HALF_BYTES);
      remain_q = 8'(HALF_BYTES);
    end
    // zero padding goes out in the same step as the length byte
    for (int i = 0; i < pad; i++)
      emit_raw(8'h00, ST_OK, is_s && len == 0 && i == pad - 1);
    if (remain_q == 0) phase_q = is_s ? P_DONE : P_S_TAG;
    else phase_q = is_s ? P_S_BODY : P_R_BODY;
  endtask

  task automatic take_int_body(input logic [7:0] b, input bit is_s);
    if (skip_q != 0) begin
      skip_q--;
    end else begin
      remain_q--;
      emit_raw(b, ST_OK, is_s && remain_q == 0);
      if (remain_q == 0) phase_q = is_s ? P_DONE : P_S_TAG;
    end
  endtask

  // Predict the raw results of one DER byte; live is low when the byte is ignored.
  task automatic convert_byte(input logic [7:0] b, input logic s, input logic e,
                              output bit live);
    status_t err;
    err  = ST_OK;
    live = 1'b0;
    step_out.delete();
    if (s) clear_parser();
    if (failed_q || phase_q == P_DONE) return;
    live = 1'b1;
    case (phase_q)
      P_SEQ_TAG: if (b != TAG_SEQUENCE) err = ST_BAD_SEQ; else phase_q = P_SEQ_LEN;
      P_SEQ_LEN: if (b < SIG_BYTES) err = ST_SHORT; else phase_q = P_R_TAG;
      P_R_TAG:   if (b != TAG_INTEGER) err = ST_BAD_R; else phase_q = P_R_LEN;
      P_R_LEN:   take_int_len(b, 1'b0);
      P_R_BODY:  take_int_body(b, 1'b0);
      P_S_TAG:   if (b != TAG_INTEGER) err = ST_BAD_S; else phase_q = P_S_LEN;
      P_S_LEN:   take_int_len(b, 1'b1);
      P_S_BODY:  take_int_body(b, 1'b1);
      default: begin
        phase_q = P_DONE;
        return;
      end
    endcase
    // frame ended before the signature was complete
    if (err == ST_OK && e && phase_q != P_DONE) err = ST_TRUNC;
    if (err != ST_OK) begin
      failed_q = 1'b1;
      emit_raw(8'h00, err, 1'b1);
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX) $display("mismatch at cycle %0d: %s", cycle_cnt, what);
  endtask

  // ------------------------------------------------------------ clock, watchdog

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still owed", cycle_cnt, raw_fifo.size());
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------- monitor
  // Sample both channels at the rising edge: check the result transaction
  // first, then predict what the accepted input transaction owes.
  always @(posedge clk) begin : monitor
    raw_result_t got;
    raw_result_t want;
    raw_result_t typed_err;
    bit          live;
    if (!rst_n) begin
      clear_parser();
      raw_fifo.delete();
    end else begin
      cycle_cnt++;
      if (pop && !empty) begin
        got.data   = out_byte;
        got.status = status_t'(out_status);
        got.last   = out_last_of_signature;
        result_cnt++;
        if (raw_fifo.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h status %0d last %0b",
                                    out_byte, out_status, out_last_of_signature));
        end else begin
          want = raw_fifo.pop_front();
          if (got.data !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", got.data, want.data));
          if (got.status !== want.status)
            report_mismatch($sformatf("out_status %0d, expected %0d (%s)",
                                      out_status, want.status, want.status.name()));
          if (got.last !== want.last)
            report_mismatch($sformatf("out_last_of_signature %0b, expected %0b",
                                      got.last, want.last));
        end
      end
      if (push && !full) begin
        convert_byte(in_byte, in_frame_start, in_frame_end, live);
        byte_cnt++;
        if (live) live_cnt++;
        // cross-check hand-typed error rows against the predictor
        if (row_typed) begin
          typed_err.data   = 8'h00;
          typed_err.status = row_status;
          typed_err.last   = 1'b1;
          if (step_out.size() != 1 || step_out[0] != typed_err)
            report_mismatch($sformatf("directed byte %02h: predictor disagrees with %s",
                                      in_byte, row_status.name()));
        end
        foreach (step_out[i]) raw_fifo.push_back(step_out[i]);
      end
    end
  end

  // -------------------------------------------------------------------- receiver
  // Stall pop at the phase's rate; on request, hold off for a long stretch so
  // the block backs up and raises full.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------- sender

  // Offer one DER byte; idle at the phase's rate first, then hold until accepted.
  // Enter and leave at a falling edge so push gets one update per step.
  task automatic send_der_byte(input logic [7:0] b, input logic s, input logic e,
                               input logic typed, input status_t st);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push           <= 1'b1;
    in_byte        <= b;
    in_frame_start <= s;
    in_frame_end   <= e;
    row_typed      <= typed;
    row_status     <= st;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Lower push and wait until every owed result has come back, plus a margin.
  task automatic stop_and_drain();
    push <= 1'b0;
    @(posedge clk);
    while (raw_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void add_byte(input logic [7:0] b, input logic s, input logic e);
    der_item_t it;
    it.b = b;
    it.s = s;
    it.e = e;
    frame_q.push_back(it);
  endfunction

  // Mostly short integers (heavy padding), some around the full width, a few
  // long enough to drop many leading bytes.
  function automatic int pick_int_len();
    int r;
    r = $urandom_range(99);
    if (r < 2) return 255;
    if (r < 10) return $urandom_range(HALF_BYTES + 8, HALF_BYTES + 1);
    if (r < 30) return $urandom_range(HALF_BYTES, HALF_BYTES - 2);
    return $urandom_range(HALF_BYTES, 0);
  endfunction

  // Build one random signature: mostly well formed with random content, some
  // corrupted, cut short, restarted midway or trailed by junk; a few pure noise.
  task automatic build_signature();
    int seq_len;
    int r_len;
    int s_len;
    int n;
    frame_q.delete();
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(6, 1);
      repeat (n) add_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
      return;
    end
    seq_len = ($urandom_range(9) == 0) ? $urandom_range(SIG_BYTES - 1, 0)
                                       : $urandom_range(255, SIG_BYTES);
    r_len = pick_int_len();
    s_len = pick_int_len();
    add_byte(TAG_SEQUENCE, 1'b0, 1'b0);
    add_byte(8'(seq_len), 1'b0, 1'b0);
    add_byte(TAG_INTEGER, 1'b0, 1'b0);
    add_byte(8'(r_len), 1'b0, 1'b0);
    repeat (r_len) add_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    add_byte(TAG_INTEGER, 1'b0, 1'b0);
    add_byte(8'(s_len), 1'b0, 1'b0);
    repeat (s_len) add_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    frame_q[0].s = ($urandom_range(9) != 0);
    frame_q[frame_q.size() - 1].e = ($urandom_range(9) != 0);
    if ($urandom_range(99) < 15)
      frame_q[$urandom_range(frame_q.size() - 1)].b = 8'($urandom_range(255));
    if ($urandom_range(99) < 12)
      frame_q[$urandom_range(frame_q.size() - 1)].e = 1'b1;
    if ($urandom_range(99) < 5)
      frame_q[$urandom_range(frame_q.size() - 1)].s = 1'b1;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(3, 1);
      repeat (n) add_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
    end
  endtask

  initial begin : stimulus
    int goal;
    rst_n          = 1'b0;
    push           = 1'b0;
    in_byte        = '0;
    in_frame_start = 1'b0;
    in_frame_end   = 1'b0;
    row_typed      = 1'b0;
    row_status     = ST_OK;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_req       = 1'b0;
    cycle_cnt      = 0;
    byte_cnt       = 0;
    live_cnt       = 0;
    result_cnt     = 0;
    frame_cnt      = 0;
    mismatch_cnt   = 0;

    // hold reset, then release it once
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // walk the directed table at full rate
    foreach (dir_rows[i])
      send_der_byte(dir_rows[i].b, dir_rows[i].s, dir_rows[i].e,
                    dir_rows[i].typed, dir_rows[i].st);
    stop_and_drain();

    // random signatures in four phases of varied idling and stalling; the first opens with a long
    // receiver hold-off while the sender keeps pushing, and every phase ends
    // with the sender paused until all results are back
    goal = byte_cnt;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_by_phase[p];
      stall_pct     = stall_by_phase[p];
      if (p == 0) hold_req = 1'b1;
      goal += RANDOM_ITEMS / 4;
      while (byte_cnt < goal) begin
        build_signature();
        frame_cnt++;
        foreach (frame_q[i])
          send_der_byte(frame_q[i].b, frame_q[i].s, frame_q[i].e, 1'b0, ST_OK);
      end
      stop_and_drain();
    end

    // nothing may be left in the block once every owed result has come back
    if (!empty) report_mismatch("result still waiting after the final drain");

    $display("covered: %0d DER bytes in (%0d parsed, rest ignored), %0d random frames",
             byte_cnt, live_cnt, frame_cnt);
    $display("covered: %0d raw results checked, %0d mismatches", result_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
